FILE: hw/rtl/att_pkg.sv
// Shared constants and types for the two-way address trace table.
package att_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int ADDR_W        = 64;
  localparam int USED_W        = 6;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_BY_VIRT = 2'd1,
    OP_BY_PHYS = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/two_way_address_trace_table.sv
// Top level of the two-way address trace table: sequencer, compare unit and result register.
//
//   Channel | Direction | Ports                      | Contents
//   --------+-----------+----------------------------+-------------------------------------
//   in      | input     | in_tvalid/tready/tdata/tuser | one request item: opcode, addresses
//   out     | output    | out_tvalid/tready/tdata    | one result item per request item
//
// An item is first accepted, then each stored entry is read and compared in
// turn, followed by a step that drains the read register, and then the result
// is posted. A lookup stops early at its first hit, an insert at its first
// clash. The scan is set by the single read port of the pair store.
// Reset (synchronous, active low) empties the table; stored addresses are not
// cleared since no entry at or above the fill count is ever read. A stalled
// result holds the sequencer in its final state; the next item is taken as
// soon as the result has moved into the output register.
module two_way_address_trace_table
  import att_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Request channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] virt_addr, [127:64] phys_addr
  input  logic [1:0]   in_tuser,   // [1:0] opcode
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // [63:0] result_addr, [64] success,
                                   // [70:65] entries_used, [71] zero
);

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [ADDR_W-1:0]   va_r, va_nxt;
  logic [ADDR_W-1:0]   pa_r, pa_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic                hit_r, hit_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [USED_W-1:0]   out_used_r, out_used_nxt;

  logic                mem_we;
  logic [ADDR_W-1:0]   rd_virt, rd_phys;
  logic                issue;
  logic                virt_eq, phys_eq, match;
  logic                ins_ok;

  att_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_virt (va_r),
    .wr_phys (pa_r),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_virt (rd_virt),
    .rd_phys (rd_phys)
  );

  // Shared compare unit: checks the entry read in the previous cycle.
  assign virt_eq = (rd_virt == va_r);
  assign phys_eq = (rd_phys == pa_r);

  always_comb begin
    case (op_r)
      OP_INSERT:  match = virt_eq | phys_eq;
      OP_BY_VIRT: match = virt_eq;
      OP_BY_PHYS: match = phys_eq;
      default:    match = 1'b0;
    endcase
  end

  // Reads are issued while entries below the fill count remain.
  assign issue  = (idx_r < count_r);
  assign ins_ok = !hit_r && (count_r < CNT_W'(TABLE_ENTRIES));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    va_nxt        = va_r;
    pa_nxt        = pa_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    res_addr_nxt  = res_addr_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_ok_nxt    = out_ok_r;
    out_used_nxt  = out_used_r;
    mem_we        = 1'b0;
    in_tready     = (state_r == S_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser;
          va_nxt       = in_tdata[63:0];
          pa_nxt       = in_tdata[127:64];
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          hit_nxt      = 1'b0;
          res_addr_nxt = '0;
          // An empty table or an unused opcode needs no scan.
          if ((count_r == '0) ||
              ((in_tuser != OP_INSERT) && (in_tuser != OP_BY_VIRT) &&
               (in_tuser != OP_BY_PHYS))) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        idx_nxt  = issue ? CNT_W'(idx_r + 1'b1) : idx_r;
        pend_nxt = issue;
        if (pend_r && match) begin
          hit_nxt  = 1'b1;
          pend_nxt = 1'b0;
          case (op_r)
            OP_BY_VIRT: res_addr_nxt = rd_phys;
            OP_BY_PHYS: res_addr_nxt = rd_virt;
            default:    res_addr_nxt = '0;
          endcase
          state_nxt = S_DONE;
        end else if (!issue) begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          case (op_r)
            OP_INSERT: begin
              out_ok_nxt = ins_ok;
              if (ins_ok) begin
                mem_we    = 1'b1;
                count_nxt = CNT_W'(count_r + 1'b1);
              end
              out_used_nxt = USED_W'(ins_ok ? CNT_W'(count_r + 1'b1) : count_r);
            end
            OP_BY_VIRT, OP_BY_PHYS: begin
              out_ok_nxt   = hit_r;
              out_used_nxt = USED_W'(count_r);
            end
            default: begin
              out_ok_nxt   = 1'b0;
              out_used_nxt = USED_W'(count_r);
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    va_r       <= va_nxt;
    pa_r       <= pa_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    res_addr_r <= res_addr_nxt;
    out_addr_r <= out_addr_nxt;
    out_ok_r   <= out_ok_nxt;
    out_used_r <= out_used_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_used_r, out_ok_r, out_addr_r};

endmodule

FILE: hw/rtl/att_store.sv
// Address pair storage: one write port and one registered read port.
module att_store
  import att_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [ADDR_W-1:0] wr_virt,
  input  logic [ADDR_W-1:0] wr_phys,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [ADDR_W-1:0] rd_virt,
  output logic [ADDR_W-1:0] rd_phys
);

  logic [ADDR_W-1:0] virt_mem [TABLE_ENTRIES];
  logic [ADDR_W-1:0] phys_mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      virt_mem[wr_addr] <= wr_virt;
      phys_mem[wr_addr] <= wr_phys;
    end
  end

  always_ff @(posedge clk) begin
    rd_virt <= virt_mem[rd_addr];
    rd_phys <= phys_mem[rd_addr];
  end

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the two-way address trace table.

// Predicts every result from the request items the block accepts and checks
// the results it sends back, in order.
class att_scoreboard;
  typedef struct packed {
    logic [63:0] addr;
    logic        hit;
    logic [5:0]  used;
  } trace_outcome_t;

  // Shadow copy of the pair store; entry k of each queue is table entry k.
  logic [63:0]    virt_tab[$];
  logic [63:0]    phys_tab[$];
  trace_outcome_t outcomes_q[$];
  int             errors;

  function int pending();
    return outcomes_q.size();
  endfunction

  // Applies one accepted request to the shadow table and queues its result.
  function void note_request(logic [1:0] op, logic [63:0] va, logic [63:0] pa);
    trace_outcome_t r;
    bit             clash;
    int             k;
    r = '0;
    clash = 1'b0;
    case (op)
      att_pkg::OP_INSERT: begin
        for (k = 0; k < virt_tab.size(); k++)
          if (virt_tab[k] == va || phys_tab[k] == pa) clash = 1'b1;
        if (!clash && virt_tab.size() < att_pkg::TABLE_ENTRIES) begin
          virt_tab.push_back(va);
          phys_tab.push_back(pa);
          r.hit = 1'b1;
        end
      end
      att_pkg::OP_BY_VIRT: begin
        // The oldest matching entry wins.
        for (k = 0; k < virt_tab.size() && !r.hit; k++)
          if (virt_tab[k] == va) begin
            r.addr = phys_tab[k];
            r.hit  = 1'b1;
          end
      end
      att_pkg::OP_BY_PHYS: begin
        for (k = 0; k < phys_tab.size() && !r.hit; k++)
          if (phys_tab[k] == pa) begin
            r.addr = virt_tab[k];
            r.hit  = 1'b1;
          end
      end
      default: ;
    endcase
    r.used = 6'(virt_tab.size());
    outcomes_q.push_back(r);
  endfunction

  function void check_result(logic [71:0] word);
    trace_outcome_t want;
    logic [63:0]    got_addr;
    logic           got_hit;
    logic [5:0]     got_used;
    got_addr = word[63:0];
    got_hit  = word[64];
    got_used = word[70:65];
    if (outcomes_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: addr %h success %b used %0d",
               $time, got_addr, got_hit, got_used);
      return;
    end
    want = outcomes_q.pop_front();
    if (got_addr !== want.addr) begin
      errors++;
      $display("%0t: result_addr mismatch: expected %h, actual %h",
               $time, want.addr, got_addr);
    end
    if (got_hit !== want.hit) begin
      errors++;
      $display("%0t: success mismatch: expected %b, actual %b",
               $time, want.hit, got_hit);
    end
    if (got_used !== want.used) begin
      errors++;
      $display("%0t: entries_used mismatch: expected %0d, actual %0d",
               $time, want.used, got_used);
    end
  endfunction
endclass

module tb;
  import att_pkg::*;

  // The opcode field is two bits wide; its fourth value is not an operation
  // but the block must still answer it.
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};
  localparam int          IDLE_PCT     = 6;
  localparam int          RANDOM_ITEMS = 2000;
  // Items in this window run with no idling on either side.
  localparam int          QUIET_FIRST  = 1000;
  localparam int          QUIET_LAST   = 1299;
  // After this many results the receiver stops taking results for a long
  // stretch, so the block fills up and pushes back on its input.
  localparam int          HOLD_AFTER   = 600;
  localparam int          HOLD_CYCLES  = 300;
  // The limit below is several times the longest expected run: the block's
  // worst case per item with a full table, plus short random gaps on both
  // sides, over every item.
  localparam int          RUN_LIMIT    = 10_000_000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;    // [63:0] virt_addr, [127:64] phys_addr
  logic [1:0]   in_tuser;    // [1:0] opcode
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;   // [63:0] result_addr, [64] success,
                             // [70:65] entries_used, [71] zero

  att_scoreboard sb;
  int            idle_pct = IDLE_PCT;

  two_way_address_trace_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offers one request item, with a random idle gap ahead of it, and hands it
  // to the scoreboard once the block has taken it. Each call starts right
  // after a rising edge, so in_tvalid gets exactly one assignment per edge.
  task automatic send_request(logic [1:0] op, logic [63:0] va, logic [63:0] pa);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pa, va};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, va, pa);
  endtask

  // Builds one random request. The shadow table supplies stored addresses, so
  // most lookups hit and some inserts collide with a stored pair.
  task automatic pick_random_request(output logic [1:0] op, output logic [63:0] va,
                                     output logic [63:0] pa);
    int unsigned roll;
    int unsigned shape;
    int unsigned pick;
    int unsigned fill;
    fill  = sb.virt_tab.size();
    va    = {$urandom, $urandom};
    pa    = {$urandom, $urandom};
    roll  = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    pick  = (fill > 0) ? $urandom_range(0, fill - 1) : 0;
    if (roll < 3) begin
      op = OP_UNUSED;
    end else if (roll < 18) begin
      op = OP_INSERT;
      // Colliding inserts: same virtual, same physical, or both.
      if (fill > 0 && shape < 10) va = sb.virt_tab[pick];
      else if (fill > 0 && shape < 20) pa = sb.phys_tab[pick];
      else if (fill > 0 && shape < 25) begin
        va = sb.virt_tab[pick];
        pa = sb.phys_tab[pick];
      end
    end else begin
      op = (roll < 59) ? OP_BY_VIRT : OP_BY_PHYS;
      if (fill > 0 && shape < 60) begin
        va = sb.virt_tab[pick];
        pa = sb.phys_tab[pick];
      end else if (fill > 0 && shape < 75) begin
        // Near miss: a stored address with one bit flipped.
        va = sb.virt_tab[pick] ^ (64'd1 << $urandom_range(0, 63));
        pa = sb.phys_tab[pick] ^ (64'd1 << $urandom_range(0, 63));
      end else if (shape < 82) begin
        va = {64{shape[0]}};
        pa = {64{shape[1]}};
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [1:0]  op;
    logic [63:0] va;
    logic [63:0] pa;
    int          n;
    sb = new;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lookups and the unused opcode on an empty table must all miss.
    send_request(OP_BY_VIRT, 64'd0, 64'd0);
    send_request(OP_BY_PHYS, 64'd0, ALL_ONES);
    send_request(OP_UNUSED, 64'd0, 64'd0);
    // Extreme address pairs, each with a zero on one side.
    send_request(OP_INSERT, 64'd0, ALL_ONES);
    send_request(OP_INSERT, ALL_ONES, 64'd0);
    // Hits in both directions, including hits whose paired address is zero.
    send_request(OP_BY_VIRT, 64'd0, 64'h1);
    send_request(OP_BY_PHYS, 64'h1, ALL_ONES);
    send_request(OP_BY_VIRT, ALL_ONES, 64'h1);
    send_request(OP_BY_PHYS, 64'h1, 64'd0);
    // Inserts that clash with a stored pair are refused.
    send_request(OP_INSERT, 64'd0, 64'h1234_5678_9abc_def0);
    send_request(OP_INSERT, 64'h0fed_cba9_8765_4321, ALL_ONES);
    send_request(OP_INSERT, ALL_ONES, 64'd0);
    send_request(OP_INSERT, 64'd0, 64'd0);
    // Alternating bit patterns, then lookups of them and a near miss.
    send_request(OP_INSERT, 64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a);
    send_request(OP_BY_VIRT, 64'ha5a5_a5a5_a5a5_a5a5, 64'd0);
    send_request(OP_BY_PHYS, 64'd0, 64'h5a5a_5a5a_5a5a_5a5a);
    send_request(OP_BY_VIRT, 64'ha5a5_a5a5_a5a5_a5a4, 64'd0);
    // The unused opcode with a populated table leaves it alone.
    send_request(OP_UNUSED, 64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a);
    send_request(OP_BY_PHYS, 64'd0, 64'h5a5a_5a5a_5a5a_5a5a);

    // Random part. The table fills within the first few hundred items, after
    // which every new insert must be refused as the table is full.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n >= QUIET_FIRST && n <= QUIET_LAST) ? 0 : IDLE_PCT;
      pick_random_request(op, va, pa);
      send_request(op, va, pa);
    end
    in_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Result side: random back-pressure and one long hold-off. A result is
  // taken at an edge where out_tvalid and out_tready were both high.
  initial begin
    int hold_left;
    int results_seen;
    bit held_once;
    hold_left    = 0;
    results_seen = 0;
    held_once    = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        results_seen++;
        if (!held_once && results_seen == HOLD_AFTER) begin
          held_once = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
